// ===== design/grm_pkg.sv =====
// shared types, codes and result tables of the gamepad button remapper
package grm_pkg;

   // request kinds
   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_SYNC = 2'd1;
   localparam logic [1:0] KIND_MODE = 2'd2;

   // result types
   localparam logic [1:0] TYPE_KEY = 2'd0;
   localparam logic [1:0] TYPE_ABS = 2'd1;
   localparam logic [1:0] TYPE_SYN = 2'd2;

   // axis codes
   localparam logic [9:0] AXIS_X = 10'd0;
   localparam logic [9:0] AXIS_Y = 10'd1;

   // button codes
   localparam logic [9:0] CODE_SOUTH      = 10'h130;
   localparam logic [9:0] CODE_EAST       = 10'h131;
   localparam logic [9:0] CODE_NORTH      = 10'h133;
   localparam logic [9:0] CODE_WEST       = 10'h134;
   localparam logic [9:0] CODE_TR2        = 10'h139;
   localparam logic [9:0] CODE_MODE       = 10'h13C;
   localparam logic [9:0] CODE_THUMBR     = 10'h13E;
   localparam logic [9:0] CODE_DPAD_UP    = 10'h220;
   localparam logic [9:0] CODE_DPAD_DOWN  = 10'h221;
   localparam logic [9:0] CODE_DPAD_LEFT  = 10'h222;
   localparam logic [9:0] CODE_DPAD_RIGHT = 10'h223;
   // c-button codes sent by shifted face buttons
   localparam logic [9:0] CODE_CBTN_1     = 10'h2C0;
   localparam logic [9:0] CODE_CBTN_2     = 10'h2C1;
   localparam logic [9:0] CODE_CBTN_3     = 10'h2C2;
   localparam logic [9:0] CODE_CBTN_4     = 10'h2C3;

   localparam logic [14:0] LEVEL_RESET = 15'd32767;

   // last index of each multi-result burst
   localparam logic [3:0] LAST_RECENTER_IDX = 4'd5;
   localparam logic [3:0] LAST_RELEASE_IDX  = 4'd10;

   // one request as taken from the input port
   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] key_code;
      logic [1:0] key_value;
      logic       mode_enable;
   } item_type;

   // one result
   typedef struct packed {
      logic [1:0]         rtype;
      logic [9:0]         code;
      logic signed [15:0] value;
   } result_type;

   // what a decoded request leaves for the emitter
   typedef enum logic [1:0] {
      BURST_NONE,
      BURST_SINGLE,
      BURST_RECENTER,
      BURST_RELEASE
   } burst_kind_type;

   typedef struct packed {
      burst_kind_type kind;
      result_type     single;
   } burst_type;

   // C-button code for a face slot when shifted
   function automatic logic [9:0] shifted_code(input logic [1:0] slot);
      logic [9:0] c;
      case (slot)
         2'd0:    c = CODE_CBTN_2;
         2'd1:    c = CODE_CBTN_4;
         2'd2:    c = CODE_CBTN_1;
         default: c = CODE_CBTN_3;
      endcase
      return c;
   endfunction

   // fixed sequence of recenter and release results
   function automatic result_type seq_entry(input logic [3:0] idx);
      result_type r;
      r.value = 16'sd0;
      case (idx)
         4'd0: begin r.rtype = TYPE_ABS; r.code = AXIS_X; end
         4'd1: begin r.rtype = TYPE_ABS; r.code = AXIS_Y; end
         4'd2: begin r.rtype = TYPE_KEY; r.code = CODE_DPAD_UP; end
         4'd3: begin r.rtype = TYPE_KEY; r.code = CODE_DPAD_DOWN; end
         4'd4: begin r.rtype = TYPE_KEY; r.code = CODE_DPAD_LEFT; end
         4'd5: begin r.rtype = TYPE_KEY; r.code = CODE_DPAD_RIGHT; end
         4'd6: begin r.rtype = TYPE_KEY; r.code = CODE_CBTN_1; end
         4'd7: begin r.rtype = TYPE_KEY; r.code = CODE_CBTN_2; end
         4'd8: begin r.rtype = TYPE_KEY; r.code = CODE_CBTN_3; end
         4'd9: begin r.rtype = TYPE_KEY; r.code = CODE_CBTN_4; end
         default: begin r.rtype = TYPE_SYN; r.code = 10'd0; end
      endcase
      return r;
   endfunction

endpackage

// ===== design/gamepad_button_remapper_unit.sv =====
// top level of the gamepad button remapper: input register, decode and result sequencer
//
//  channel  dir  handshake           payload
//  req      in   req_valid/req_stall kind, key_code, key_value, mode_enable
//  rsp      out  rsp_valid/rsp_stall out_type, out_code, out_value, last
//  csr      in   csr_valid/csr_ready analog_level (15 bits)
//
// a request is registered, decoded in the next cycle and its results go out one per cycle while rsp_stall is low
// a single request gives one result, a recenter burst 6 results, a shift-off release 11
// the result sequencer sets the rate; a request with no result retires without waiting for the sequencer
// first result is offered once the request has passed the input register and been loaded into the burst register
// synchronous reset clears all mode state and face latches, level returns to 32767
// req_stall rises while the sequencer still holds results of the request before
module gamepad_button_remapper_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [9:0]         req_key_code,
   input  logic [1:0]         req_key_value,
   input  logic               req_mode_enable,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_type,
   output logic [9:0]         rsp_out_code,
   output logic signed [15:0] rsp_out_value,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [14:0]        csr_data
);

   logic               in_valid_ff, in_valid_in;
   grm_pkg::item_type  item_ff, item_in;
   grm_pkg::burst_type desc;
   logic               free;
   logic               retire;
   logic               load;
   logic               req_take;

   // request retires when it gives nothing or the sequencer can take it
   assign retire    = in_valid_ff && (desc.kind == grm_pkg::BURST_NONE || free);
   assign load      = retire && desc.kind != grm_pkg::BURST_NONE;
   assign req_stall = in_valid_ff && !retire;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_take) begin
         in_valid_in         = 1'b1;
         item_in.kind        = req_kind;
         item_in.key_code    = req_key_code;
         item_in.key_value   = req_key_value;
         item_in.mode_enable = req_mode_enable;
      end else if (retire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   grm_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .item     (item_ff),
      .fire     (retire),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .desc     (desc)
   );

   grm_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .desc          (desc),
      .free          (free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_type  (rsp_out_type),
      .rsp_out_code  (rsp_out_code),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== design/grm_decode.sv =====
// remapper state and per-request decode into a result burst
module grm_decode (
   input  logic                clock,
   input  logic                reset,
   input  grm_pkg::item_type   item,
   input  logic                fire,
   input  logic                csr_we,
   input  logic [14:0]         csr_data,
   output grm_pkg::burst_type  desc
);

   logic [14:0] level_ff, level_in;
   logic        analog_ff, analog_in;
   logic        mode_held_ff, mode_held_in;
   logic        shift_ff, shift_in;
   logic        r2_ff, r2_in;
   logic [9:0]  latch_ff [4];
   logic [9:0]  latch_in [4];

   logic        is_face;
   logic [1:0]  slot;
   logic [9:0]  latched;
   logic [15:0] mag;
   logic [15:0] key_val16;

   // face slot lookup
   always_comb begin
      is_face = 1'b1;
      slot    = 2'd0;
      case (item.key_code)
         grm_pkg::CODE_SOUTH: slot = 2'd0;
         grm_pkg::CODE_EAST:  slot = 2'd1;
         grm_pkg::CODE_NORTH: slot = 2'd2;
         grm_pkg::CODE_WEST:  slot = 2'd3;
         default:             is_face = 1'b0;
      endcase
   end

   assign key_val16 = {14'd0, item.key_value};
   assign mag       = (item.key_value != 2'd0) ? {1'b0, level_ff} : 16'd0;

   // decode and next state
   always_comb begin
      analog_in    = analog_ff;
      mode_held_in = mode_held_ff;
      shift_in     = shift_ff;
      r2_in        = r2_ff;
      for (int i = 0; i < 4; i++) latch_in[i] = latch_ff[i];
      latched            = 10'd0;
      desc.kind          = grm_pkg::BURST_NONE;
      desc.single.rtype  = grm_pkg::TYPE_KEY;
      desc.single.code   = item.key_code;
      desc.single.value  = key_val16;

      case (item.kind)
         grm_pkg::KIND_SYNC: begin
            desc.kind         = grm_pkg::BURST_SINGLE;
            desc.single.rtype = grm_pkg::TYPE_SYN;
            desc.single.code  = 10'd0;
            desc.single.value = 16'sd0;
         end
         grm_pkg::KIND_MODE: begin
            shift_in = item.mode_enable;
            if (!item.mode_enable) begin
               analog_in = 1'b0;
               for (int i = 0; i < 4; i++) latch_in[i] = 10'd0;
               desc.kind = grm_pkg::BURST_RELEASE;
            end
         end
         grm_pkg::KIND_KEY: begin
            if (is_face) begin
               // latch at press, release with the latched code
               if (item.key_value == 2'd1) begin
                  latched = (shift_ff && r2_ff) ? grm_pkg::shifted_code(slot) : item.key_code;
               end else begin
                  latched = latch_ff[slot];
               end
               desc.kind        = grm_pkg::BURST_SINGLE;
               desc.single.code = (latched != 10'd0) ? latched : item.key_code;
               if (item.key_value == 2'd1) latch_in[slot] = latched;
               else if (item.key_value == 2'd0) latch_in[slot] = 10'd0;
            end else begin
               case (item.key_code)
                  grm_pkg::CODE_TR2: begin
                     r2_in = (item.key_value != 2'd0);
                     if (!shift_ff) desc.kind = grm_pkg::BURST_SINGLE;
                  end
                  grm_pkg::CODE_MODE: begin
                     mode_held_in = (item.key_value != 2'd0);
                     desc.kind    = grm_pkg::BURST_SINGLE;
                  end
                  grm_pkg::CODE_THUMBR: begin
                     if (mode_held_ff && item.key_value == 2'd1) begin
                        analog_in = !analog_ff;
                        desc.kind = grm_pkg::BURST_RECENTER;
                     end else if (!mode_held_ff) begin
                        desc.kind = grm_pkg::BURST_SINGLE;
                     end
                  end
                  grm_pkg::CODE_DPAD_UP, grm_pkg::CODE_DPAD_DOWN,
                  grm_pkg::CODE_DPAD_LEFT, grm_pkg::CODE_DPAD_RIGHT: begin
                     desc.kind = grm_pkg::BURST_SINGLE;
                     if (analog_ff) begin
                        desc.single.rtype = grm_pkg::TYPE_ABS;
                        desc.single.code  = (item.key_code == grm_pkg::CODE_DPAD_UP ||
                                             item.key_code == grm_pkg::CODE_DPAD_DOWN)
                                            ? grm_pkg::AXIS_Y : grm_pkg::AXIS_X;
                        // up and left point negative
                        desc.single.value = (item.key_code == grm_pkg::CODE_DPAD_UP ||
                                             item.key_code == grm_pkg::CODE_DPAD_LEFT)
                                            ? (~mag + 16'd1) : mag;
                     end
                  end
                  default: desc.kind = grm_pkg::BURST_SINGLE;
               endcase
            end
         end
         default: desc.kind = grm_pkg::BURST_NONE;
      endcase
   end

   assign level_in = csr_we ? csr_data : level_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= grm_pkg::LEVEL_RESET;
         analog_ff    <= 1'b0;
         mode_held_ff <= 1'b0;
         shift_ff     <= 1'b0;
         r2_ff        <= 1'b0;
         for (int i = 0; i < 4; i++) latch_ff[i] <= 10'd0;
      end else begin
         level_ff <= level_in;
         if (fire) begin
            analog_ff    <= analog_in;
            mode_held_ff <= mode_held_in;
            shift_ff     <= shift_in;
            r2_ff        <= r2_in;
            for (int i = 0; i < 4; i++) latch_ff[i] <= latch_in[i];
         end
      end
   end

endmodule

// ===== design/grm_emit.sv =====
// result burst register and sequencer driving the response port
module grm_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  grm_pkg::burst_type  desc,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_out_type,
   output logic [9:0]          rsp_out_code,
   output logic signed [15:0]  rsp_out_value,
   output logic                rsp_last
);

   logic                   valid_ff, valid_in;
   grm_pkg::burst_kind_type kind_ff, kind_in;
   grm_pkg::result_type    single_ff, single_in;
   logic [3:0]             idx_ff, idx_in;
   grm_pkg::result_type    cur;
   logic                   is_last;
   logic                   take;

   // current result and end of burst
   always_comb begin
      case (kind_ff)
         grm_pkg::BURST_RECENTER: begin
            cur     = grm_pkg::seq_entry(idx_ff);
            is_last = (idx_ff == grm_pkg::LAST_RECENTER_IDX);
         end
         grm_pkg::BURST_RELEASE: begin
            cur     = grm_pkg::seq_entry(idx_ff);
            is_last = (idx_ff == grm_pkg::LAST_RELEASE_IDX);
         end
         default: begin
            cur     = single_ff;
            is_last = 1'b1;
         end
      endcase
   end

   assign take = valid_ff && !rsp_stall;
   assign free = !valid_ff || (take && is_last);

   // burst register next state
   always_comb begin
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      single_in = single_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = 1'b1;
         kind_in   = desc.kind;
         single_in = desc.single;
         idx_in    = 4'd0;
      end else if (take) begin
         if (is_last) valid_in = 1'b0;
         else idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         kind_ff  <= grm_pkg::BURST_SINGLE;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      single_ff <= single_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_type  = cur.rtype;
   assign rsp_out_code  = cur.code;
   assign rsp_out_value = cur.value;
   assign rsp_last      = is_last;

`ifndef SYNTH
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= grm_pkg::LAST_RELEASE_IDX)
      else $error("burst index out of range");

   a_single_idx: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == grm_pkg::BURST_SINGLE |-> idx_ff == 4'd0)
      else $error("single result burst advanced its index");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free && desc.kind != grm_pkg::BURST_NONE)
      else $error("burst loaded over a busy register");

   a_step: assert property (@(posedge clock) disable iff (reset)
      take && !is_last |=> valid_ff && idx_ff == $past(idx_ff) + 4'd1)
      else $error("burst did not step to the next result");
`endif

endmodule
